### rtl/fsa_pkg.sv
// Shared types and constants for the free list slot allocator.
package fsa_pkg;

	localparam int MODE_W    = 2;
	localparam int HANDLE_W  = 8;
	localparam int PAYLOAD_W = 32;
	localparam int STATUS_W  = 2;
	localparam int ENTRY_W   = 7;
	localparam int COUNT_W   = 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_READ    = 2'd2
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK         = 2'd0,
		STAT_POOL_FULL  = 2'd1,
		STAT_RANGE      = 2'd2,
		STAT_STACK_FULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'b01,
		FSM_EXEC = 2'b10
	} fsm_t;

	typedef struct packed {
		status_t                status;
		logic [ENTRY_W-1:0]     granted_handle;
		logic [PAYLOAD_W-1:0]   read_data;
		logic [COUNT_W-1:0]     free_slots;
	} rsp_t;

endpackage

### rtl/fsa_if.sv
// Request and response channel interfaces of the free list slot allocator.
interface fsa_req_if import fsa_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [MODE_W-1:0]    mode;
	logic [HANDLE_W-1:0]  handle;
	logic [PAYLOAD_W-1:0] payload;

	modport source (output valid, output mode, output handle, output payload, input ready);
	modport sink (input valid, input mode, input handle, input payload, output ready);
endinterface

interface fsa_rsp_if import fsa_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [ENTRY_W-1:0]   granted_handle;
	logic [PAYLOAD_W-1:0] read_data;
	logic [COUNT_W-1:0]   free_slots;

	modport source (output valid, output status, output granted_handle, output read_data,
		output free_slots, input ready);
	modport sink (input valid, input status, input granted_handle, input read_data,
		input free_slots, output ready);
endinterface

### rtl/fsa_ram.sv
// Generic single write port, single read port RAM with registered read data.
module fsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/free_list_slot_allocator_unit.sv
// Top level of the free list slot allocator: LIFO handle stack and slot payload store.
//
//   channel  direction  beat contents
//   req      in         mode, handle, payload
//   rsp      out        status, granted_handle, read_data, free_slots
//
// Each request passes through FSM_IDLE, which presents the read addresses to the stack
// and slot RAMs, and FSM_EXEC, which uses the registered read data, writes back and
// loads the response register. A new request is taken once the previous one has left
// FSM_EXEC. Reset clears the per-entry valid bits, so stack entries read as their own
// index and slots read as zero until first written; no clearing pass.
// A stalled response holds FSM_EXEC; the request side is then not ready.
module free_list_slot_allocator_unit import fsa_pkg::*; #(
	parameter int SLOTS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	fsa_req_if.sink   req,
	fsa_rsp_if.source rsp
);

	localparam int PTR_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	fsm_t                 state_q;
	logic [MODE_W-1:0]    mode_q;
	logic [HANDLE_W-1:0]  handle_q;
	logic [PAYLOAD_W-1:0] payload_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     cnt_nxt;
	logic [SLOTS-1:0]     stk_vld_q;
	logic [SLOTS-1:0]     slot_vld_q;
	logic                 out_vld_q;
	rsp_t                 out_q;
	rsp_t                 rsp_nxt;

	logic                 accept;
	logic                 done;
	logic [PTR_W-1:0]     pop_addr;
	logic [ENTRY_W-1:0]   stk_rdata;
	logic [ENTRY_W-1:0]   pop_h;
	logic                 pop_in_range;
	logic                 handle_in_range;
	logic                 stk_we;
	logic [PTR_W-1:0]     slot_raddr;
	logic [PAYLOAD_W-1:0] slot_rdata;
	logic                 slot_we;
	logic [PTR_W-1:0]     slot_waddr;
	logic [PAYLOAD_W-1:0] slot_wdata;

	assign req.ready = (state_q == FSM_IDLE);
	assign accept    = req.valid && req.ready;
	assign done      = (state_q == FSM_EXEC) && (!out_vld_q || rsp.ready);

	// The top of the stack sits one below the free count; the count only moves
	// when an operation completes, so this address stays put while it waits.
	assign pop_addr   = PTR_W'(cnt_q - 1'b1);
	assign slot_raddr = (state_q == FSM_IDLE) ? req.handle[PTR_W-1:0] : handle_q[PTR_W-1:0];

	fsa_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (cnt_q[PTR_W-1:0]),
		.wdata (handle_q[ENTRY_W-1:0]),
		.raddr (pop_addr),
		.rdata (stk_rdata)
	);

	fsa_ram #(.WIDTH(PAYLOAD_W), .DEPTH(SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	assign pop_h           = stk_vld_q[pop_addr] ? stk_rdata : ENTRY_W'(pop_addr);
	assign pop_in_range    = (ENTRY_W + 1)'(pop_h) < (ENTRY_W + 1)'(SLOTS);
	assign handle_in_range = handle_q < HANDLE_W'(SLOTS);

	always_comb begin
		rsp_nxt                = '0;
		rsp_nxt.status         = STAT_OK;
		cnt_nxt                = cnt_q;
		stk_we                 = 1'b0;
		slot_we                = 1'b0;
		slot_waddr             = handle_q[PTR_W-1:0];
		slot_wdata             = '0;
		unique case (mode_q)
			MODE_ALLOC: begin
				if (cnt_q == '0) begin
					rsp_nxt.status = STAT_POOL_FULL;
				end else begin
					cnt_nxt                = cnt_q - 1'b1;
					rsp_nxt.granted_handle = pop_h;
					slot_we                = done && pop_in_range;
					slot_waddr             = PTR_W'(pop_h);
					slot_wdata             = payload_q;
				end
			end
			MODE_RELEASE: begin
				if (!handle_in_range) begin
					rsp_nxt.status = STAT_RANGE;
				end else if (cnt_q >= CNT_W'(SLOTS)) begin
					rsp_nxt.status = STAT_STACK_FULL;
				end else begin
					cnt_nxt = cnt_q + 1'b1;
					stk_we  = done;
					slot_we = done;
				end
			end
			MODE_READ: begin
				if (!handle_in_range) begin
					rsp_nxt.status = STAT_RANGE;
				end else if (slot_vld_q[handle_q[PTR_W-1:0]]) begin
					rsp_nxt.read_data = slot_rdata;
				end
			end
			default: begin
			end
		endcase
		rsp_nxt.free_slots = COUNT_W'(cnt_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FSM_IDLE;
			cnt_q      <= CNT_W'(SLOTS);
			stk_vld_q  <= '0;
			slot_vld_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			unique case (state_q)
				FSM_IDLE: begin
					if (accept) begin
						state_q <= FSM_EXEC;
					end
				end
				FSM_EXEC: begin
					if (done) begin
						state_q <= FSM_IDLE;
					end
				end
				default: begin
					state_q <= FSM_IDLE;
				end
			endcase
			if (done) begin
				cnt_q <= cnt_nxt;
				if (stk_we) begin
					stk_vld_q[cnt_q[PTR_W-1:0]] <= 1'b1;
				end
				if (slot_we) begin
					slot_vld_q[slot_waddr] <= 1'b1;
				end
			end
			if (done) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q    <= req.mode;
			handle_q  <= req.handle;
			payload_q <= req.payload;
		end
		if (done) begin
			out_q <= rsp_nxt;
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.status         = out_q.status;
	assign rsp.granted_handle = out_q.granted_handle;
	assign rsp.read_data      = out_q.read_data;
	assign rsp.free_slots     = out_q.free_slots;

endmodule

### rtl/fsa_chk.sv
// Port-level checks for the free list slot allocator, bound to the top level.
module fsa_chk import fsa_pkg::*; #(
	parameter int SLOTS = 64
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [STATUS_W-1:0]  rsp_status,
	input logic [ENTRY_W-1:0]   rsp_granted_handle,
	input logic [PAYLOAD_W-1:0] rsp_read_data,
	input logic [COUNT_W-1:0]   rsp_free_slots
);

	// A response beat waits until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_free_slots <= COUNT_W'(SLOTS))
		else $error("free slot count above pool size");

	a_pool_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_POOL_FULL |->
			rsp_free_slots == '0 && rsp_granted_handle == '0)
		else $error("pool full reported with free slots or a grant");

	a_stack_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_STACK_FULL |-> rsp_free_slots == COUNT_W'(SLOTS))
		else $error("double free reported while the stack has room");

	a_err_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STAT_OK |-> rsp_read_data == '0)
		else $error("read data on a failed operation");

endmodule

bind free_list_slot_allocator_unit fsa_chk #(.SLOTS(SLOTS)) u_fsa_chk (
	.clk                (clk),
	.arst_n             (arst_n),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_status         (rsp.status),
	.rsp_granted_handle (rsp.granted_handle),
	.rsp_read_data      (rsp.read_data),
	.rsp_free_slots     (rsp.free_slots)
);
